// ===== hdl/gti_pkg.sv =====
// ----------------------------------------------------------------------------
// gti_pkg: shared types and constants for the grid triangle index generator
// Index width, register indexes and the cell request passed front to back.
// ----------------------------------------------------------------------------
package gti_pkg;

  localparam int INDEX_BITS = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_GRID_COLUMNS = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_GRID_ROWS    = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DOUBLE_SIDED = 2'd2;

  localparam logic [INDEX_BITS-1:0] GRID_RESET_SIZE = 16'd2;

  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_BITS = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CMD_CNT_BITS = $clog2(CMD_DEPTH + 1);

  typedef logic [INDEX_BITS-1:0] index_t;

  typedef struct packed {
    index_t grid_columns;
    index_t grid_rows;
    logic   double_sided;
  } cfg_t;

  // one cell to emit
  typedef struct packed {
    index_t row_pos;
    index_t next_row;
    index_t column_pos;
    index_t grid_columns;
    logic   back_pass;
    logic   grid_done;
  } cmd_t;

endpackage

// ===== hdl/gti_front.sv =====
// ----------------------------------------------------------------------------
// gti_front: cell walker
// Accepts requests, steps the grid position and queues one cell command
// per request that produces triangles.
// ----------------------------------------------------------------------------
module gti_front import gti_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic req_valid,
  input  logic req_restart,
  input  logic cmd_full,
  output logic req_ready,
  output logic cmd_push,
  output cmd_t cmd
);

  index_t col_r, col_nxt;
  index_t row_r, row_nxt;
  index_t cnt_r, cnt_nxt;
  logic   back_r, back_nxt;
  logic   fin_r, fin_nxt;

  index_t col_s, row_s, cnt_s, next_row, cnt_dec;
  logic   back_s, fin_s, grid_empty, row_end, accept;

  assign req_ready = !cmd_full;
  assign accept    = req_valid && !cmd_full;

  always_comb begin
    grid_empty = (cfg.grid_columns < GRID_RESET_SIZE) || (cfg.grid_rows < GRID_RESET_SIZE);
    col_s  = req_restart ? '0 : col_r;
    row_s  = req_restart ? '0 : row_r;
    back_s = req_restart ? 1'b0 : back_r;
    if (req_restart) begin
      fin_s = grid_empty;
      cnt_s = grid_empty ? '0 : cfg.grid_rows - 16'd1;
    end else begin
      fin_s = fin_r;
      cnt_s = cnt_r;
    end

    next_row = back_s ? row_s - 16'd1 : row_s + 16'd1;
    cnt_dec  = cnt_s - 16'd1;
    // a row ends once the next column would reach the last vertex column
    row_end  = (cfg.grid_columns < GRID_RESET_SIZE) ||
               (({1'b0, col_s} + 17'd1) >= {1'b0, cfg.grid_columns - 16'd1});

    col_nxt  = col_s;
    row_nxt  = row_s;
    cnt_nxt  = cnt_s;
    back_nxt = back_s;
    fin_nxt  = fin_s;
    if (!fin_s) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = next_row;
        cnt_nxt = cnt_dec;
        if (cnt_dec == '0) begin
          if (!back_s && cfg.double_sided && !(cfg.grid_rows < GRID_RESET_SIZE)) begin
            back_nxt = 1'b1;
            row_nxt  = cfg.grid_rows - 16'd1;
            cnt_nxt  = cfg.grid_rows - 16'd1;
          end else begin
            fin_nxt = 1'b1;
          end
        end
      end else begin
        col_nxt = col_s + 16'd1;
      end
    end

    cmd.row_pos      = row_s;
    cmd.next_row     = next_row;
    cmd.column_pos   = col_s;
    cmd.grid_columns = cfg.grid_columns;
    cmd.back_pass    = back_s;
    cmd.grid_done    = fin_nxt;
    cmd_push         = accept && !fin_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      cnt_r  <= '0;
      back_r <= 1'b0;
      fin_r  <= 1'b1;
    end else if (accept) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      cnt_r  <= cnt_nxt;
      back_r <= back_nxt;
      fin_r  <= fin_nxt;
    end
  end

endmodule

// ===== hdl/gti_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// gti_cmd_fifo: cell command queue
// Short register queue that decouples the walker from the index datapath.
// ----------------------------------------------------------------------------
module gti_cmd_fifo import gti_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t mem_r [CMD_DEPTH];
  logic [CMD_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMD_PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMD_CNT_BITS-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign full    = (count_r == CMD_CNT_BITS'(CMD_DEPTH));
  assign empty   = (count_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == CMD_PTR_BITS'(CMD_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == CMD_PTR_BITS'(CMD_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hdl/gti_back.sv =====
// ----------------------------------------------------------------------------
// gti_back: index datapath
// Multiplies out the two row bases of a cell and emits its two triangles,
// one per cycle while the result is popped.
// ----------------------------------------------------------------------------
module gti_back import gti_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   cmd_valid,
  input  cmd_t   cmd,
  output logic   cmd_pop,
  output logic   out_empty,
  input  logic   out_pop,
  output index_t out_index_first,
  output index_t out_index_second,
  output index_t out_index_third,
  output logic   out_back_pass,
  output logic   out_cell_last,
  output logic   out_grid_done
);

  logic   valid_r, valid_nxt;
  logic   phase_r, phase_nxt;
  index_t base_cur_r, base_nbr_r;
  logic   back_r, done_r;
  logic   load;
  logic [2*INDEX_BITS-1:0] prod_cur, prod_nbr;
  index_t base_cur, base_nbr;

  assign prod_cur = {{INDEX_BITS{1'b0}}, cmd.row_pos}  * {{INDEX_BITS{1'b0}}, cmd.grid_columns};
  assign prod_nbr = {{INDEX_BITS{1'b0}}, cmd.next_row} * {{INDEX_BITS{1'b0}}, cmd.grid_columns};
  assign base_cur = prod_cur[INDEX_BITS-1:0] + cmd.column_pos;
  assign base_nbr = prod_nbr[INDEX_BITS-1:0] + cmd.column_pos;

  // take the next cell when idle or as the second triangle leaves
  assign load    = cmd_valid && (!valid_r || (out_pop && phase_r));
  assign cmd_pop = load;

  always_comb begin
    valid_nxt = valid_r;
    phase_nxt = phase_r;
    if (load) begin
      valid_nxt = 1'b1;
      phase_nxt = 1'b0;
    end else if (valid_r && out_pop) begin
      if (phase_r) begin
        valid_nxt = 1'b0;
        phase_nxt = 1'b0;
      end else begin
        phase_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      base_cur_r <= base_cur;
      base_nbr_r <= base_nbr;
      back_r     <= cmd.back_pass;
      done_r     <= cmd.grid_done;
    end
  end

  assign out_empty        = !valid_r;
  assign out_index_first  = phase_r ? base_nbr_r + 16'd1 : base_nbr_r;
  assign out_index_second = base_cur_r;
  assign out_index_third  = phase_r ? base_cur_r + 16'd1 : base_nbr_r + 16'd1;
  assign out_back_pass    = back_r;
  assign out_cell_last    = phase_r;
  assign out_grid_done    = phase_r && done_r;

endmodule

// ===== hdl/grid_triangle_index_generator_top.sv =====
// A request accepted by the walker is written into the command queue; the index datapath
//   then loads it from the queue head into its registers and shows its first triangle.
// Throughput: one triangle per cycle on the result side while pop is held and cells are
//   queued; the index datapath's two-triangle emit per cell limits the request rate.
// Requests yielding nothing (finished, empty grid) are taken at one per cycle if not full.
// Reset (synchronous, rst_n low): queues empty, grid finished, registers back to
//   2 columns, 2 rows, single sided.
// ----------------------------------------------------------------------------
// grid_triangle_index_generator_top: regular grid triangle-list indexer
// Configuration registers, walker front, command queue and index back end.
// ----------------------------------------------------------------------------
module grid_triangle_index_generator_top import gti_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      push,
  output logic                      full,
  input  logic                      in_restart,
  output logic                      empty,
  input  logic                      pop,
  output logic [INDEX_BITS-1:0]     out_index_first,
  output logic [INDEX_BITS-1:0]     out_index_second,
  output logic [INDEX_BITS-1:0]     out_index_third,
  output logic                      out_back_pass,
  output logic                      out_cell_last,
  output logic                      out_grid_done
);

  cfg_t cfg_r;
  cmd_t front_cmd, fifo_head;
  logic front_push, fifo_full, fifo_empty, back_pop, front_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_columns <= GRID_RESET_SIZE;
      cfg_r.grid_rows    <= GRID_RESET_SIZE;
      cfg_r.double_sided <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_COLUMNS: cfg_r.grid_columns <= cfg_data[INDEX_BITS-1:0];
        CFG_GRID_ROWS:    cfg_r.grid_rows    <= cfg_data[INDEX_BITS-1:0];
        CFG_DOUBLE_SIDED: cfg_r.double_sided <= cfg_data[0];
        default: ;
      endcase
    end
  end

  gti_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .req_valid   (push),
    .req_restart (in_restart),
    .cmd_full    (fifo_full),
    .req_ready   (front_ready),
    .cmd_push    (front_push),
    .cmd         (front_cmd)
  );

  assign full = !front_ready;

  gti_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_push),
    .push_data (front_cmd),
    .full      (fifo_full),
    .pop       (back_pop),
    .empty     (fifo_empty),
    .head      (fifo_head)
  );

  gti_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (!fifo_empty),
    .cmd              (fifo_head),
    .cmd_pop          (back_pop),
    .out_empty        (empty),
    .out_pop          (pop),
    .out_index_first  (out_index_first),
    .out_index_second (out_index_second),
    .out_index_third  (out_index_third),
    .out_back_pass    (out_back_pass),
    .out_cell_last    (out_cell_last),
    .out_grid_done    (out_grid_done)
  );

endmodule

// ===== hdl/gti_checker.sv =====
// ----------------------------------------------------------------------------
// gti_checker: port-level checks for the grid triangle index generator
// Watches the request and result ports of the top level.
// ----------------------------------------------------------------------------
module gti_checker import gti_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  full,
  input logic                  empty,
  input logic                  pop,
  input logic [INDEX_BITS-1:0] out_index_first,
  input logic [INDEX_BITS-1:0] out_index_second,
  input logic [INDEX_BITS-1:0] out_index_third,
  input logic                  out_cell_last,
  input logic                  out_grid_done
);

  // a held result does not change
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_index_first) &&
      $stable(out_index_second) && $stable(out_index_third))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not empty after reset");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_grid_done |-> out_cell_last)
    else $error("grid done on first triangle of a cell");

  // second triangle of a cell shares the diagonal with the first
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && pop && !out_cell_last |=> !empty && out_cell_last &&
      out_index_first == $past(out_index_third) &&
      out_index_second == $past(out_index_second))
    else $error("triangle pair does not share its diagonal");

endmodule

bind grid_triangle_index_generator_top gti_checker u_gti_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .full             (full),
  .empty            (empty),
  .pop              (pop),
  .out_index_first  (out_index_first),
  .out_index_second (out_index_second),
  .out_index_third  (out_index_third),
  .out_cell_last    (out_cell_last),
  .out_grid_done    (out_grid_done)
);
